// ----- hdl/i2cm_pkg.sv -----
`default_nettype none

package i2cm_pkg;

  localparam int unsigned DivW = 16;
  localparam int unsigned HalfW = 16;
  localparam int unsigned AckW = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW = 16;
  localparam int unsigned InUserW = 4;
  localparam int unsigned OutDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgHalfPeriod = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAckTimeout = 1'b1;

  localparam logic [2:0] CmdStart = 3'd0;
  localparam logic [2:0] CmdStop = 3'd1;
  localparam logic [2:0] CmdWrite = 3'd2;
  localparam logic [2:0] CmdReadAck = 3'd3;
  localparam logic [2:0] CmdReadNack = 3'd4;

  typedef struct packed {
    logic [HalfW-1:0] half_period;
    logic [AckW-1:0]  ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       ack_timeout;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/i2cm_core.sv -----
`default_nettype none

module i2cm_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire i2cm_pkg::cfg_t cfg_i,
  input  wire logic          cmd_valid_i,
  input  wire logic [2:0]    cmd_i,
  input  wire logic [7:0]    tx_byte_i,
  input  wire logic          sda_in_i,
  output i2cm_pkg::res_t     res_o
);
  import i2cm_pkg::*;

  typedef enum logic [21:0] {
    PhIdle   = 22'd1 << 0,
    PhStA    = 22'd1 << 1,
    PhStB    = 22'd1 << 2,
    PhStC    = 22'd1 << 3,
    PhSpA    = 22'd1 << 4,
    PhSpB    = 22'd1 << 5,
    PhSpC    = 22'd1 << 6,
    PhWrPre  = 22'd1 << 7,
    PhWrSet  = 22'd1 << 8,
    PhWrHigh = 22'd1 << 9,
    PhWrLow  = 22'd1 << 10,
    PhAkRel  = 22'd1 << 11,
    PhAkPoll = 22'd1 << 12,
    PhAkLow  = 22'd1 << 13,
    PhRdPre  = 22'd1 << 14,
    PhRdH1   = 22'd1 << 15,
    PhRdH2   = 22'd1 << 16,
    PhRdL    = 22'd1 << 17,
    PhMaA    = 22'd1 << 18,
    PhMaB    = 22'd1 << 19,
    PhMaC    = 22'd1 << 20,
    PhMaD    = 22'd1 << 21
  } phase_e;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drive;
  } line_t;

  localparam logic [32:0] DivMax = 33'((64'd1 << DivW) - 64'd1);

  phase_e          ph_q, ph_d, tgt;
  logic [2:0]      act_q, act_d;
  logic [3:0]      bit_q, bit_d;
  logic [7:0]      shift_q, shift_d;
  logic [DivW-1:0] tick_q, tick_d, eff;
  logic [AckW-1:0] wait_q, wait_d;
  line_t           line_q, line_d;
  logic [1:0]      flags_q, flags_d;
  logic [7:0]      rx_q, rx_d;
  logic            do_enter, done;
  logic [32:0]     hp_ext;

  function automatic line_t enter_lines(phase_e p, line_t cur, logic msb, logic ackbit);
    line_t l;
    l = cur;
    unique case (p)
      PhStA:    l = '{1'b1, 1'b1, 1'b1};
      PhStB:    l = '{1'b1, 1'b0, 1'b1};
      PhStC:    l = '{1'b0, 1'b0, 1'b1};
      PhSpA:    l = '{1'b0, 1'b0, 1'b1};
      PhSpB:    l = '{1'b1, 1'b0, 1'b1};
      PhSpC:    l = '{1'b1, 1'b1, 1'b1};
      PhWrPre:  l = '{1'b0, cur.sda, 1'b1};
      PhWrSet:  l = '{1'b0, msb, 1'b1};
      PhWrHigh: l = '{1'b1, msb, 1'b1};
      PhWrLow:  l = '{1'b0, msb, 1'b1};
      PhAkRel:  l = '{1'b0, cur.sda, 1'b0};
      PhAkPoll: l = '{1'b1, cur.sda, 1'b0};
      PhAkLow:  l = '{1'b0, cur.sda, 1'b0};
      PhRdPre:  l = '{1'b0, cur.sda, 1'b0};
      PhRdH1:   l = '{1'b1, cur.sda, 1'b0};
      PhRdH2:   l = '{1'b1, cur.sda, 1'b0};
      PhRdL:    l = '{1'b0, cur.sda, 1'b0};
      PhMaA:    l = '{1'b0, cur.sda, 1'b0};
      PhMaB:    l = '{1'b0, ackbit, 1'b1};
      PhMaC:    l = '{1'b1, ackbit, 1'b1};
      PhMaD:    l = '{1'b0, ackbit, 1'b1};
      default:  l = cur;
    endcase
    return l;
  endfunction

  // Effective half period: zero counts as one, large values saturate.
  always_comb begin
    hp_ext = {{(33 - HalfW){1'b0}}, cfg_i.half_period};
    if (hp_ext == 33'd0) begin
      eff = DivW'(1);
    end else if (hp_ext > DivMax) begin
      eff = DivMax[DivW-1:0];
    end else begin
      eff = hp_ext[DivW-1:0];
    end
  end

  always_comb begin
    ph_d     = ph_q;
    act_d    = act_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    tick_d   = tick_q;
    wait_d   = wait_q;
    line_d   = line_q;
    flags_d  = flags_q;
    rx_d     = rx_q;
    do_enter = 1'b0;
    tgt      = PhIdle;
    done     = 1'b0;

    if (ph_q == PhIdle) begin
      if (cmd_valid_i && (cmd_i <= CmdReadNack)) begin
        act_d    = cmd_i;
        bit_d    = 4'd0;
        do_enter = 1'b1;
        if (cmd_i == CmdStart) begin
          tgt = PhStA;
        end else if (cmd_i == CmdStop) begin
          tgt = PhSpA;
        end else if (cmd_i == CmdWrite) begin
          flags_d = 2'b00;
          shift_d = tx_byte_i;
          tgt     = PhWrPre;
        end else begin
          shift_d = 8'd0;
          tgt     = PhRdPre;
        end
      end
    end else if (ph_q == PhAkPoll) begin
      if (!sda_in_i) begin
        flags_d[0] = 1'b1;
        do_enter   = 1'b1;
        tgt        = PhAkLow;
      end else if (wait_q >= cfg_i.ack_timeout) begin
        flags_d[1] = 1'b1;
        do_enter   = 1'b1;
        tgt        = PhSpA;
      end else begin
        wait_d = wait_q + AckW'(1);
      end
    end else if (tick_q > DivW'(1)) begin
      tick_d = tick_q - DivW'(1);
    end else begin
      do_enter = 1'b1;
      unique case (ph_q)
        PhStA:    tgt = PhStB;
        PhStB:    tgt = PhStC;
        PhSpA:    tgt = PhSpB;
        PhSpB:    tgt = PhSpC;
        PhWrPre:  tgt = PhWrSet;
        PhWrSet:  tgt = PhWrHigh;
        PhWrHigh: tgt = PhWrLow;
        PhWrLow: begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_q + 4'd1;
          tgt     = (bit_d >= 4'd8) ? PhAkRel : PhWrSet;
        end
        PhAkRel:  tgt = PhAkPoll;
        PhRdPre:  tgt = PhRdH1;
        PhRdH1: begin
          shift_d = {shift_q[6:0], sda_in_i};
          tgt     = PhRdH2;
        end
        PhRdH2:   tgt = PhRdL;
        PhRdL: begin
          bit_d = bit_q + 4'd1;
          if (bit_d >= 4'd8) begin
            rx_d = shift_q;
            tgt  = PhMaA;
          end else begin
            tgt = PhRdH1;
          end
        end
        PhMaA:    tgt = PhMaB;
        PhMaB:    tgt = PhMaC;
        PhMaC:    tgt = PhMaD;
        PhStC, PhSpC, PhAkLow, PhMaD: begin
          do_enter = 1'b0;
          ph_d     = PhIdle;
          tick_d   = '0;
          done     = 1'b1;
        end
        default: begin
          do_enter = 1'b0;
          ph_d     = PhIdle;
          tick_d   = '0;
        end
      endcase
    end

    if (do_enter) begin
      ph_d   = tgt;
      tick_d = eff;
      line_d = enter_lines(tgt, line_q, shift_d[7], act_d == CmdReadNack);
      if (tgt == PhAkPoll) begin
        wait_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PhIdle;
      act_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      tick_q  <= '0;
      wait_q  <= '0;
      line_q  <= '{1'b1, 1'b1, 1'b0};
      flags_q <= '0;
      rx_q    <= '0;
    end else if (en_i) begin
      ph_q    <= ph_d;
      act_q   <= act_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      tick_q  <= tick_d;
      wait_q  <= wait_d;
      line_q  <= line_d;
      flags_q <= flags_d;
      rx_q    <= rx_d;
    end
  end

  always_comb begin
    res_o.scl         = line_d.scl;
    res_o.sda         = line_d.sda;
    res_o.drive       = line_d.drive;
    res_o.busy        = (ph_d != PhIdle);
    res_o.done        = done;
    res_o.rx_byte     = rx_d;
    res_o.ack_seen    = flags_d[0];
    res_o.ack_timeout = flags_d[1];
  end

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(ph_q))
    else $error("Phase register lost its one-hot code.");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flags_q[0] && flags_q[1]))
    else $error("Acknowledge and timeout flags are both set.");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && done |=> ph_q == PhIdle)
    else $error("Command completed but the engine did not return to idle.");

  a_poll_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PhAkPoll |-> !line_q.drive && line_q.scl)
    else $error("SDA is driven or SCL is low while polling for acknowledge.");

endmodule

`default_nettype wire

// ----- hdl/i2c_master_byte_engine.sv -----
// The result for a tick transaction is registered and appears in the cycle after it is taken.
// Throughput: one tick transaction per cycle while results are taken; the state update for a tick is a single
// combinational pass between the engine state registers and the output register.
// A result waiting in the output register blocks the input; the next tick enters in the
// cycle that result is taken.
// Reset is asynchronous and active low: engine idle, SCL high, SDA released, registers at defaults.
`default_nettype none

module i2c_master_byte_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [i2cm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [i2cm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tx_byte[7:0], sda_in[8], zero fill above.
  input  wire logic [i2cm_pkg::InDataW-1:0]  s_axis_tdata,
  // cmd_valid[0], cmd[3:1].
  input  wire logic [i2cm_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // scl_out[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4], rx_byte[12:5],
  // ack_seen[13], ack_timeout[14], zero fill above.
  output logic [i2cm_pkg::OutDataW-1:0]      m_axis_tdata
);
  import i2cm_pkg::*;

  cfg_t                cfg_q;
  res_t                res;
  logic                accept;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= HalfW'(10);
      cfg_q.ack_timeout <= AckW'(250);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfPeriod: cfg_q.half_period <= cfg_wdata_i[HalfW-1:0];
        CfgAckTimeout: cfg_q.ack_timeout <= cfg_wdata_i[AckW-1:0];
        default: ;
      endcase
    end
  end

  i2cm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .cfg_i       (cfg_q),
    .cmd_valid_i (s_axis_tuser[0]),
    .cmd_i       (s_axis_tuser[3:1]),
    .tx_byte_i   (s_axis_tdata[7:0]),
    .sda_in_i    (s_axis_tdata[8]),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {1'b0, res.ack_timeout, res.ack_seen, res.rx_byte, res.done,
                     res.busy, res.drive, res.sda, res.scl};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- bench/tb_i2c_master_byte_engine.sv -----
`timescale 1ns / 100ps

module tb_i2c_master_byte_engine;
  import i2cm_pkg::*;

  localparam int NoAck = 1 << 20;

  typedef enum logic [4:0] {
    PhIdle, PhStA, PhStB, PhStC, PhSpA, PhSpB, PhSpC,
    PhWrPre, PhWrSet, PhWrHigh, PhWrLow, PhAkRel, PhAkPoll, PhAkLow,
    PhRdPre, PhRdH1, PhRdH2, PhRdL, PhMaA, PhMaB, PhMaC, PhMaD
  } bus_phase_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  i2c_master_byte_engine i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expected engine state, mirrored tick by tick.
  bus_phase_e  ph;
  logic [2:0]  act_cmd;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [15:0] hold_cnt;
  logic [9:0]  poll_cnt;
  logic        scl_q, sda_q, drv_q;
  logic [1:0]  flags;
  logic [7:0]  rx_hold;
  logic [HalfW-1:0] half_cfg;
  logic [AckW-1:0]  ack_cfg;

  res_t tick_results_q[$];
  res_t want_r, got_r;
  int   mismatches = 0;
  int   ticks_sent = 0;
  bit   quiet = 1'b0;
  bit   noise_on = 1'b0;
  int   ack_after = 0;
  logic [7:0] slave_byte = '0;
  int   stall_left = 0;

  function automatic void model_reset();
    half_cfg = 16'd10;
    ack_cfg = 10'd250;
    ph = PhIdle;
    act_cmd = '0;
    bit_cnt = '0;
    shreg = '0;
    hold_cnt = '0;
    poll_cnt = '0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    drv_q = 1'b0;
    flags = '0;
    rx_hold = '0;
  endfunction

  function automatic void put_lines(logic scl, logic sda, logic drv);
    scl_q = scl;
    sda_q = sda;
    drv_q = drv;
  endfunction

  function automatic void enter_phase(bus_phase_e p);
    logic msb, ackbit;
    msb = shreg[7];
    ackbit = (act_cmd == CmdReadNack);
    ph = p;
    hold_cnt = (half_cfg == '0) ? 16'd1 : half_cfg;
    case (p)
      PhStA: put_lines(1'b1, 1'b1, 1'b1);
      PhStB: put_lines(1'b1, 1'b0, 1'b1);
      PhStC: put_lines(1'b0, 1'b0, 1'b1);
      PhSpA: put_lines(1'b0, 1'b0, 1'b1);
      PhSpB: put_lines(1'b1, 1'b0, 1'b1);
      PhSpC: put_lines(1'b1, 1'b1, 1'b1);
      PhWrPre: put_lines(1'b0, sda_q, 1'b1);
      PhWrSet: put_lines(1'b0, msb, 1'b1);
      PhWrHigh: put_lines(1'b1, msb, 1'b1);
      PhWrLow: put_lines(1'b0, msb, 1'b1);
      PhAkRel: put_lines(1'b0, sda_q, 1'b0);
      PhAkPoll: begin
        put_lines(1'b1, sda_q, 1'b0);
        poll_cnt = '0;
      end
      PhAkLow: put_lines(1'b0, sda_q, 1'b0);
      PhRdPre: put_lines(1'b0, sda_q, 1'b0);
      PhRdH1: put_lines(1'b1, sda_q, 1'b0);
      PhRdH2: put_lines(1'b1, sda_q, 1'b0);
      PhRdL: put_lines(1'b0, sda_q, 1'b0);
      PhMaA: put_lines(1'b0, sda_q, 1'b0);
      PhMaB: put_lines(1'b0, ackbit, 1'b1);
      PhMaC: put_lines(1'b1, ackbit, 1'b1);
      PhMaD: put_lines(1'b0, ackbit, 1'b1);
      default: begin
        ph = PhIdle;
        hold_cnt = '0;
      end
    endcase
  endfunction

  // Moves on at the end of a timed phase and returns 1 when the command completes.
  function automatic logic finish_phase(logic sda);
    case (ph)
      PhStA: enter_phase(PhStB);
      PhStB: enter_phase(PhStC);
      PhSpA: enter_phase(PhSpB);
      PhSpB: enter_phase(PhSpC);
      PhWrPre: enter_phase(PhWrSet);
      PhWrSet: enter_phase(PhWrHigh);
      PhWrHigh: enter_phase(PhWrLow);
      PhWrLow: begin
        shreg = shreg << 1;
        bit_cnt = bit_cnt + 4'd1;
        enter_phase(bit_cnt >= 4'd8 ? PhAkRel : PhWrSet);
      end
      PhAkRel: enter_phase(PhAkPoll);
      PhRdPre: enter_phase(PhRdH1);
      PhRdH1: begin
        shreg = {shreg[6:0], sda};
        enter_phase(PhRdH2);
      end
      PhRdH2: enter_phase(PhRdL);
      PhRdL: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          rx_hold = shreg;
          enter_phase(PhMaA);
        end else begin
          enter_phase(PhRdH1);
        end
      end
      PhMaA: enter_phase(PhMaB);
      PhMaB: enter_phase(PhMaC);
      PhMaC: enter_phase(PhMaD);
      PhStC, PhSpC, PhAkLow, PhMaD: begin
        ph = PhIdle;
        hold_cnt = '0;
        return 1'b1;
      end
      default: begin
        ph = PhIdle;
        hold_cnt = '0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic res_t engine_tick(logic cv, logic [2:0] c, logic [7:0] txb, logic sda);
    res_t r;
    logic done;
    done = 1'b0;
    if (ph == PhIdle) begin
      if (cv && c <= CmdReadNack) begin
        act_cmd = c;
        bit_cnt = '0;
        case (c)
          CmdStart: enter_phase(PhStA);
          CmdStop: enter_phase(PhSpA);
          CmdWrite: begin
            flags = '0;
            shreg = txb;
            enter_phase(PhWrPre);
          end
          default: begin
            shreg = '0;
            enter_phase(PhRdPre);
          end
        endcase
      end
    end else if (ph == PhAkPoll) begin
      if (!sda) begin
        flags[0] = 1'b1;
        enter_phase(PhAkLow);
      end else if (poll_cnt >= ack_cfg) begin
        flags[1] = 1'b1;
        enter_phase(PhSpA);
      end else begin
        poll_cnt = poll_cnt + 10'd1;
      end
    end else if (hold_cnt > 16'd1) begin
      hold_cnt = hold_cnt - 16'd1;
    end else begin
      done = finish_phase(sda);
    end
    r.scl = scl_q;
    r.sda = sda_q;
    r.drive = drv_q;
    r.busy = (ph != PhIdle);
    r.done = done;
    r.rx_byte = rx_hold;
    r.ack_seen = flags[0];
    r.ack_timeout = flags[1];
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tick_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want_r = tick_results_q.pop_front();
        got_r.scl = m_axis_tdata[0];
        got_r.sda = m_axis_tdata[1];
        got_r.drive = m_axis_tdata[2];
        got_r.busy = m_axis_tdata[3];
        got_r.done = m_axis_tdata[4];
        got_r.rx_byte = m_axis_tdata[12:5];
        got_r.ack_seen = m_axis_tdata[13];
        got_r.ack_timeout = m_axis_tdata[14];
        check_field("scl_out", 8'(want_r.scl), 8'(got_r.scl));
        check_field("sda_out", 8'(want_r.sda), 8'(got_r.sda));
        check_field("sda_drive", 8'(want_r.drive), 8'(got_r.drive));
        check_field("busy", 8'(want_r.busy), 8'(got_r.busy));
        check_field("done", 8'(want_r.done), 8'(got_r.done));
        check_field("rx_byte", want_r.rx_byte, got_r.rx_byte);
        check_field("ack_seen", 8'(want_r.ack_seen), 8'(got_r.ack_seen));
        check_field("ack_timeout", 8'(want_r.ack_timeout), 8'(got_r.ack_timeout));
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  always @(negedge clk_i) begin
    if (quiet || stall_left == 0) begin
      m_axis_tready = 1'b1;
      stall_left = pick_gap();
    end else begin
      m_axis_tready = 1'b0;
      stall_left--;
    end
  end

  // Called just after a falling edge; returns just after the falling edge that follows the tick's acceptance.
  task automatic send_tick(logic cv, logic [2:0] c, logic [7:0] txb, logic sda);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {7'b0, sda, txb};
    s_axis_tuser = {c, cv};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    tick_results_q.push_back(engine_tick(cv, c, txb, sda));
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // The slave side: acknowledges after a set number of polled ticks and
  // presents its byte while SCL is high in a read.
  function automatic logic slave_sda();
    if (ph == PhAkPoll) return (int'(poll_cnt) >= ack_after) ? 1'b0 : 1'b1;
    if (ph == PhRdH1) return slave_byte[3'd7 - bit_cnt[2:0]];
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic bus_cmd(logic [2:0] c, logic [7:0] data, int ack_delay);
    ack_after = ack_delay;
    slave_byte = data;
    send_tick(1'b1, c, (c == CmdWrite) ? data : 8'($urandom), 1'($urandom));
    while (ph != PhIdle) begin
      send_tick(noise_on && ($urandom_range(0, 3) == 0), 3'($urandom), 8'($urandom),
                slave_sda());
    end
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    s_axis_tvalid = 1'b0;
    while (tick_results_q.size() != 0) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgHalfPeriod) begin
      half_cfg = data[HalfW-1:0];
    end else begin
      ack_cfg = data[AckW-1:0];
    end
  endtask

  task automatic test_reset_config_transfers();
    repeat (3) send_tick(1'b0, CmdStart, 8'($urandom), 1'($urandom));
    bus_cmd(CmdStart, 8'h00, 0);
    bus_cmd(CmdStop, 8'h00, 0);
  endtask

  task automatic test_ignored_commands();
    write_cfg(CfgHalfPeriod, 16'd2);
    bus_cmd(3'd5, 8'hFF, 0);
    bus_cmd(3'd6, 8'h00, 0);
    bus_cmd(3'd7, 8'h81, 0);
    noise_on = 1'b1;
    bus_cmd(CmdStart, 8'h00, 0);
    bus_cmd(CmdWrite, 8'h6E, 2);
    bus_cmd(CmdReadNack, 8'h91, 0);
    bus_cmd(CmdStop, 8'h00, 0);
    noise_on = 1'b0;
  endtask

  task automatic test_register_extremes();
    write_cfg(CfgHalfPeriod, 16'd1);
    write_cfg(CfgAckTimeout, 16'd1);
    bus_cmd(CmdStart, 8'h00, 0);
    bus_cmd(CmdWrite, 8'h00, 0);
    bus_cmd(CmdWrite, 8'hFF, 1);
    bus_cmd(CmdWrite, 8'h81, NoAck);
    bus_cmd(CmdReadAck, 8'hFF, 0);
    bus_cmd(CmdReadNack, 8'h00, 0);
    write_cfg(CfgAckTimeout, 16'd0);
    bus_cmd(CmdWrite, 8'h3C, NoAck);
    quiet = 1'b1;
    write_cfg(CfgAckTimeout, 16'hFC02);
    bus_cmd(CmdWrite, 8'h96, NoAck);
    write_cfg(CfgHalfPeriod, 16'd0);
    bus_cmd(CmdStart, 8'h00, 0);
    bus_cmd(CmdStop, 8'h00, 0);
    write_cfg(CfgHalfPeriod, 16'd25);
    bus_cmd(CmdStop, 8'h00, 0);
    quiet = 1'b0;
  endtask

  function automatic int pick_ack();
    if ($urandom_range(0, 4) == 0) return NoAck;
    return $urandom_range(0, int'(ack_cfg));
  endfunction

  task automatic random_segment(logic [15:0] half, logic [15:0] ack, bit no_idle, int n_ticks);
    int stop_at, k;
    write_cfg(CfgHalfPeriod, half);
    write_cfg(CfgAckTimeout, ack);
    quiet = no_idle;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      noise_on = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 6) == 0) begin
        // Stray items: unknown codes or a lone command out of sequence.
        bus_cmd(3'($urandom), 8'($urandom), pick_ack());
      end else begin
        bus_cmd(CmdStart, 8'h00, 0);
        bus_cmd(CmdWrite, 8'($urandom), pick_ack());
        k = $urandom_range(0, 3);
        repeat (k) begin
          if ($urandom_range(0, 1)) begin
            bus_cmd(CmdWrite, 8'($urandom), pick_ack());
          end else begin
            bus_cmd($urandom_range(0, 1) ? CmdReadAck : CmdReadNack, 8'($urandom), 0);
          end
        end
        bus_cmd(CmdStop, 8'h00, 0);
      end
    end
    noise_on = 1'b0;
    quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    random_segment(16'd1, 16'd2, 1'b0, 100);
    random_segment(16'd2, 16'd5, 1'b1, 60);
    random_segment(16'd1, 16'd0, 1'b0, 80);
  endtask

  initial begin
    int n;
    model_reset();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_config_transfers();
    test_ignored_commands();
    test_register_extremes();
    test_random_traffic();
    s_axis_tvalid = 1'b0;
    for (n = 0; n < 2000 && tick_results_q.size() != 0; n++) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (tick_results_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tick_results_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("%0t: timeout", $time);
    $display("FAIL");
    $finish;
  end

endmodule
